// ----- rtl/core/rplm_pkg.sv -----
// ----------------------------------------------------------------------------
// Reclaim pressure level monitor package
// Shared widths, reset values, field codes and state types.
// ----------------------------------------------------------------------------
`default_nettype none

package rplm_pkg;

    localparam int SUM_WIDTH_DEF = 32;

    localparam int CNT_W  = 24;
    localparam int WIN_W  = 24;
    localparam int PCT_W  = 7;
    localparam int THR_W  = 7;
    localparam int PRIO_W = 4;
    localparam int MODE_W = 2;
    localparam int LVL_W  = 2;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 24;

    localparam logic [WIN_W-1:0]  WIN_RST   = 24'd512;
    localparam logic [THR_W-1:0]  MED_RST   = 7'd60;
    localparam logic [THR_W-1:0]  CRIT_RST  = 7'd95;
    localparam logic [PRIO_W-1:0] CPRIO_RST = 4'd3;

    localparam logic [MODE_W-1:0] MODE_TREE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOCAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PRIO  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSVD  = 2'd3;

    localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MED  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_CRIT = 2'd2;

    localparam logic [IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MED    = 2'd1;
    localparam logic [IDX_W-1:0] CFG_CRIT   = 2'd2;
    localparam logic [IDX_W-1:0] CFG_CPRIO  = 2'd3;

    localparam logic KIND_TREE  = 1'b0;
    localparam logic KIND_LOCAL = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACC,
        S_CALC,
        S_OUT
    } t_mon_state;

    typedef enum logic [2:0] {
        D_IDLE,
        D_SQR,
        D_PART,
        D_MUL,
        D_MUL2,
        D_DIV,
        D_DONE
    } t_div_state;

endpackage

`default_nettype wire

// ----- rtl/core/rplm_div.sv -----
// ----------------------------------------------------------------------------
// Pressure calculation unit
// Bit-serial computation of the window pressure percent from the scanned
// and reclaimed sums: a squaring remainder loop, then a restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module rplm_div #(
    parameter int SUM_WIDTH = rplm_pkg::SUM_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [SUM_WIDTH-1:0]       i_s,
    input  logic [SUM_WIDTH-1:0]       i_r,
    output logic                       o_done,
    output logic [rplm_pkg::PCT_W-1:0] o_pct
);
    import rplm_pkg::*;

    localparam int CW = $clog2(SUM_WIDTH);
    localparam int DW = SUM_WIDTH + 1;
    localparam int TW = SUM_WIDTH + 2;
    localparam int NW = SUM_WIDTH + 7;

    t_div_state           r_state, n_state;
    logic [SUM_WIDTH-1:0] r_s, n_s;
    logic [SUM_WIDTH-1:0] r_r, n_r;
    logic [SUM_WIDTH-1:0] r_rsh, n_rsh;
    logic [SUM_WIDTH-1:0] r_rem, n_rem;
    logic [SUM_WIDTH-1:0] r_q, n_q;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [DW-1:0]        r_d, n_d;
    logic [NW-1:0]        r_num, n_num;
    logic [NW-1:0]        r_dsh, n_dsh;
    logic [PCT_W-1:0]     r_pq, n_pq;
    logic [2:0]           r_dcnt, n_dcnt;

    logic [TW-1:0] t, s1, s2, t_m1, t_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s    <= n_s;
        r_r    <= n_r;
        r_rsh  <= n_rsh;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
        r_d    <= n_d;
        r_num  <= n_num;
        r_dsh  <= n_dsh;
        r_pq   <= n_pq;
        r_dcnt <= n_dcnt;
    end

    assign s1   = {2'b00, r_s};
    assign s2   = {1'b0, r_s, 1'b0};
    assign t    = {1'b0, r_rem, 1'b0} + (r_rsh[SUM_WIDTH-1] ? {2'b00, r_r} : '0);
    assign t_m1 = t - s1;
    assign t_m2 = t - s2;

    assign o_pct = r_pq;

    always_comb begin
        n_state = r_state;
        n_s     = r_s;
        n_r     = r_r;
        n_rsh   = r_rsh;
        n_rem   = r_rem;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_d     = r_d;
        n_num   = r_num;
        n_dsh   = r_dsh;
        n_pq    = r_pq;
        n_dcnt  = r_dcnt;
        o_done  = 1'b0;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_s   = i_s;
                    n_r   = i_r;
                    n_rsh = i_r;
                    n_rem = '0;
                    n_q   = '0;
                    n_cnt = CW'(SUM_WIDTH - 1);
                    if (i_r >= i_s) begin
                        n_pq    = '0;
                        n_state = D_DONE;
                    end else begin
                        n_state = D_SQR;
                    end
                end
            end
            D_SQR: begin
                if (t >= s2) begin
                    n_rem = t_m2[SUM_WIDTH-1:0];
                    n_q   = {r_q[SUM_WIDTH-2:0], 1'b0} + SUM_WIDTH'(2);
                end else if (t >= s1) begin
                    n_rem = t_m1[SUM_WIDTH-1:0];
                    n_q   = {r_q[SUM_WIDTH-2:0], 1'b1};
                end else begin
                    n_rem = t[SUM_WIDTH-1:0];
                    n_q   = {r_q[SUM_WIDTH-2:0], 1'b0};
                end
                n_rsh = {r_rsh[SUM_WIDTH-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = D_PART;
                end else begin
                    n_cnt = r_cnt - CW'(1);
                end
            end
            D_PART: begin
                n_q     = r_s - r_q;
                n_d     = {1'b0, r_s} + {1'b0, r_r};
                n_state = D_MUL;
            end
            D_MUL: begin
                n_num   = {1'b0, r_q, 6'b0} + {2'b00, r_q, 5'b0};
                n_dsh   = {r_d, 6'b0};
                n_dcnt  = 3'd6;
                n_pq    = '0;
                n_state = D_MUL2;
            end
            D_MUL2: begin
                n_num   = r_num + {5'b0, r_q, 2'b00};
                n_state = D_DIV;
            end
            D_DIV: begin
                if (r_num >= r_dsh) begin
                    n_num = r_num - r_dsh;
                    n_pq  = {r_pq[PCT_W-2:0], 1'b1};
                end else begin
                    n_pq  = {r_pq[PCT_W-2:0], 1'b0};
                end
                n_dsh = r_dsh >> 1;
                if (r_dcnt == 3'd0) begin
                    n_state = D_DONE;
                end else begin
                    n_dcnt = r_dcnt - 3'd1;
                end
            end
            D_DONE: begin
                o_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/reclaim_pressure_level_monitor.sv -----
// ----------------------------------------------------------------------------
// Reclaim pressure level monitor
// Accumulates tree and local reclaim reports into saturating sums and, when a
// window fills, reports its pressure percent, level and socket-pressure flag.
// ----------------------------------------------------------------------------
// One item at a time: the input is stalled from acceptance until the item is done.
// An item that closes no window returns to idle after the accumulate state. One that
// closes a window with reclaimed below scanned runs the divider through the bit-serial
// squaring loop and then the percent divide before its result is registered; with
// reclaimed at or above scanned the percent is zero. A stalled output holds a result back.
// Synchronous active-low reset clears all sums and the output valid flag and loads defaults.
`default_nettype none

module reclaim_pressure_level_monitor #(
    parameter int SUM_WIDTH = rplm_pkg::SUM_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rplm_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [rplm_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [rplm_pkg::MODE_W-1:0] i_mode,
    input  logic                        i_reclaim_allowed,
    input  logic                        i_is_root,
    input  logic [rplm_pkg::CNT_W-1:0]  i_scanned_count,
    input  logic [rplm_pkg::CNT_W-1:0]  i_reclaimed_count,
    input  logic [rplm_pkg::PRIO_W-1:0] i_priority_req,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [rplm_pkg::LVL_W-1:0]  o_level,
    output logic [rplm_pkg::PCT_W-1:0]  o_pressure_percent,
    output logic                        o_window_kind,
    output logic                        o_socket_pressure
);
    import rplm_pkg::*;

    localparam int AW = ((SUM_WIDTH > WIN_W) ? SUM_WIDTH : WIN_W) + 1;
    localparam logic [AW-1:0] SUM_MAX_E = {{(AW-SUM_WIDTH){1'b0}}, {SUM_WIDTH{1'b1}}};

    t_mon_state r_state, n_state;

    logic [WIN_W-1:0]  r_win;
    logic [THR_W-1:0]  r_med;
    logic [THR_W-1:0]  r_crit;
    logic [PRIO_W-1:0] r_cprio;

    logic [SUM_WIDTH-1:0] r_tree_s, n_tree_s;
    logic [SUM_WIDTH-1:0] r_tree_r, n_tree_r;
    logic [SUM_WIDTH-1:0] r_loc_s, n_loc_s;
    logic [SUM_WIDTH-1:0] r_loc_r, n_loc_r;

    logic [MODE_W-1:0] r_mode;
    logic              r_allowed;
    logic              r_root;
    logic [CNT_W-1:0]  r_sc;
    logic [CNT_W-1:0]  r_rc;
    logic [PRIO_W-1:0] r_prio;

    logic                 r_kind, n_kind;
    logic [PCT_W-1:0]     r_pct, n_pct;

    logic             r_o_valid, n_o_valid;
    logic [LVL_W-1:0] r_o_level, n_o_level;
    logic [PCT_W-1:0] r_o_pct, n_o_pct;
    logic             r_o_kind, n_o_kind;
    logic             r_o_sock, n_o_sock;

    logic                 in_take;
    logic                 eff_tree;
    logic                 drop;
    logic [CNT_W-1:0]     eff_sc;
    logic [CNT_W-1:0]     eff_rc;
    logic [SUM_WIDTH-1:0] a_s, a_r;
    logic [AW-1:0]        sum_s, sum_r;
    logic [SUM_WIDTH-1:0] sat_s, sat_r;
    logic                 full;
    logic [LVL_W-1:0]     lvl;
    logic                 div_start;
    logic                 div_done;
    logic [PCT_W-1:0]     div_pct;

    rplm_div #(
        .SUM_WIDTH(SUM_WIDTH)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_s    (sat_s),
        .i_r    (sat_r),
        .o_done (div_done),
        .o_pct  (div_pct)
    );

    assign o_stall            = (r_state != S_IDLE);
    assign in_take            = i_valid && !o_stall;
    assign o_valid            = r_o_valid;
    assign o_level            = r_o_level;
    assign o_pressure_percent = r_o_pct;
    assign o_window_kind      = r_o_kind;
    assign o_socket_pressure  = r_o_sock;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= WIN_RST;
            r_med   <= MED_RST;
            r_crit  <= CRIT_RST;
            r_cprio <= CPRIO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW: r_win   <= i_cfg_data[WIN_W-1:0];
                CFG_MED:    r_med   <= i_cfg_data[THR_W-1:0];
                CFG_CRIT:   r_crit  <= i_cfg_data[THR_W-1:0];
                CFG_CPRIO:  r_cprio <= i_cfg_data[PRIO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tree_s  <= '0;
            r_tree_r  <= '0;
            r_loc_s   <= '0;
            r_loc_r   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_tree_s  <= n_tree_s;
            r_tree_r  <= n_tree_r;
            r_loc_s   <= n_loc_s;
            r_loc_r   <= n_loc_r;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode    <= i_mode;
            r_allowed <= i_reclaim_allowed;
            r_root    <= i_is_root;
            r_sc      <= i_scanned_count;
            r_rc      <= i_reclaimed_count;
            r_prio    <= i_priority_req;
        end
        r_kind    <= n_kind;
        r_pct     <= n_pct;
        r_o_level <= n_o_level;
        r_o_pct   <= n_o_pct;
        r_o_kind  <= n_o_kind;
        r_o_sock  <= n_o_sock;
    end

    always_comb begin
        eff_tree = (r_mode == MODE_TREE) || (r_mode == MODE_PRIO);
        eff_sc   = (r_mode == MODE_PRIO) ? r_win : r_sc;
        eff_rc   = (r_mode == MODE_PRIO) ? '0 : r_rc;
        drop     = (r_mode == MODE_RSVD)
                || ((r_mode == MODE_PRIO) && (r_prio > r_cprio))
                || !r_allowed
                || (eff_sc == '0)
                || ((r_mode == MODE_LOCAL) && r_root);
        a_s   = eff_tree ? r_tree_s : r_loc_s;
        a_r   = eff_tree ? r_tree_r : r_loc_r;
        sum_s = {{(AW-SUM_WIDTH){1'b0}}, a_s} + {{(AW-WIN_W){1'b0}}, eff_sc};
        sum_r = {{(AW-SUM_WIDTH){1'b0}}, a_r} + {{(AW-WIN_W){1'b0}}, eff_rc};
        sat_s = (sum_s > SUM_MAX_E) ? {SUM_WIDTH{1'b1}} : sum_s[SUM_WIDTH-1:0];
        sat_r = (sum_r > SUM_MAX_E) ? {SUM_WIDTH{1'b1}} : sum_r[SUM_WIDTH-1:0];
        full  = ({{(AW-SUM_WIDTH){1'b0}}, sat_s} >= {{(AW-WIN_W){1'b0}}, r_win});

        if (r_pct >= r_crit) begin
            lvl = LVL_CRIT;
        end else if (r_pct >= r_med) begin
            lvl = LVL_MED;
        end else begin
            lvl = LVL_LOW;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_tree_s  = r_tree_s;
        n_tree_r  = r_tree_r;
        n_loc_s   = r_loc_s;
        n_loc_r   = r_loc_r;
        n_kind    = r_kind;
        n_pct     = r_pct;
        n_o_valid = r_o_valid && i_stall;
        n_o_level = r_o_level;
        n_o_pct   = r_o_pct;
        n_o_kind  = r_o_kind;
        n_o_sock  = r_o_sock;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = S_IDLE;
                if (!drop) begin
                    if (full) begin
                        n_kind    = eff_tree ? KIND_TREE : KIND_LOCAL;
                        div_start = 1'b1;
                        n_state   = S_CALC;
                    end
                    if (eff_tree) begin
                        n_tree_s = full ? '0 : sat_s;
                        n_tree_r = full ? '0 : sat_r;
                    end else begin
                        n_loc_s = full ? '0 : sat_s;
                        n_loc_r = full ? '0 : sat_r;
                    end
                end
            end
            S_CALC: begin
                if (div_done) begin
                    n_pct   = div_pct;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    n_o_level = lvl;
                    n_o_pct   = r_pct;
                    n_o_kind  = r_kind;
                    n_o_sock  = (r_kind == KIND_LOCAL) && (lvl != LVL_LOW);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
